FILE: rtl/core/tgarle_pkg.sv
// Package for the TGA RLE pixel decoder core.
// Result beat type, register indexes and size constants; no dependencies.
package tgarle_pkg;

    localparam int unsigned PixelW    = 32;
    localparam int unsigned RepeatW   = 8;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 32;
    localparam int unsigned QueueDepth = 4;

    localparam logic [CfgIdxW-1:0] CfgBytesPerPixel = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgImagePixels   = CfgIdxW'(1);

    localparam logic [ByteW-1:0] HdrRunBias = ByteW'(127);
    localparam logic [2:0]       BppBgra    = 3'd4;
    localparam logic [1:0]       LastPosBgr  = 2'd2;
    localparam logic [1:0]       LastPosBgra = 2'd3;

    typedef struct packed {
        logic [PixelW-1:0]  pixel_value;
        logic [RepeatW-1:0] repeat_count;
        logic               image_done;
        logic               clipped;
    } t_result;

endpackage

FILE: rtl/core/tgarle_front.sv
// Front end: packet header parse, pixel byte assembly and image pixel count.
// Depends on tgarle_pkg; feeds result beats into tgarle_fifo.
module tgarle_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tgarle_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [tgarle_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                             i_beat,
    input  logic [tgarle_pkg::ByteW-1:0]     i_data_byte,
    output logic                             o_res_valid,
    output tgarle_pkg::t_result              o_res
);
    import tgarle_pkg::*;

    logic                r_bpp4, n_bpp4;
    logic [PixelW-1:0]   r_img_total, n_img_total;
    logic                r_expect_hdr, n_expect_hdr;
    logic                r_run, n_run;
    logic [RepeatW-1:0]  r_pkt_left, n_pkt_left;
    logic [1:0]          r_pos, n_pos;
    logic [PixelW-1:0]   r_pix, n_pix;
    logic [PixelW-1:0]   r_img_left, n_img_left;

    logic [PixelW-1:0]   pix_acc;
    logic                last_byte;
    logic                run_over;
    logic [RepeatW-1:0]  rep;
    logic [RepeatW-1:0]  pkt_after;
    logic [PixelW-1:0]   img_after;
    logic                done;
    logic                clip;

    always_comb begin
        pix_acc   = r_pix | (PixelW'(i_data_byte) << {r_pos, 3'b000});
        last_byte = (r_pos == (r_bpp4 ? LastPosBgra : LastPosBgr));
        run_over  = (PixelW'(r_pkt_left) > r_img_left);
        if (r_run) begin
            rep       = run_over ? r_img_left[RepeatW-1:0] : r_pkt_left;
            pkt_after = '0;
        end else begin
            rep       = RepeatW'(1);
            pkt_after = r_pkt_left - RepeatW'(1);
        end
        img_after = r_img_left - PixelW'(rep);
        done      = (img_after == '0);
        clip      = r_run ? run_over : (done && (pkt_after != '0));
    end

    always_comb begin
        n_bpp4       = r_bpp4;
        n_img_total  = r_img_total;
        n_expect_hdr = r_expect_hdr;
        n_run        = r_run;
        n_pkt_left   = r_pkt_left;
        n_pos        = r_pos;
        n_pix        = r_pix;
        n_img_left   = r_img_left;
        o_res_valid  = 1'b0;
        if (i_cfg_we) begin
            if (i_cfg_index == CfgBytesPerPixel) begin
                n_bpp4 = (i_cfg_data[2:0] == BppBgra);
            end else if (i_cfg_index == CfgImagePixels) begin
                n_img_total = (i_cfg_data == '0) ? PixelW'(1) : i_cfg_data;
            end
            if (i_cfg_index == CfgBytesPerPixel || i_cfg_index == CfgImagePixels) begin
                n_expect_hdr = 1'b1;
                n_run        = 1'b0;
                n_pkt_left   = '0;
                n_pos        = '0;
                n_pix        = '0;
                n_img_left   = n_img_total;
            end
        end else if (i_beat) begin
            if (r_expect_hdr) begin
                n_run        = i_data_byte[ByteW-1];
                n_pkt_left   = i_data_byte[ByteW-1] ? (i_data_byte - HdrRunBias)
                                                    : (i_data_byte + ByteW'(1));
                n_pos        = '0;
                n_pix        = '0;
                n_expect_hdr = 1'b0;
            end else if (!last_byte) begin
                n_pix = pix_acc;
                n_pos = r_pos + 2'd1;
            end else begin
                o_res_valid = 1'b1;
                n_pos       = '0;
                n_pix       = '0;
                n_pkt_left  = pkt_after;
                n_img_left  = img_after;
                if (done) begin
                    n_img_left   = r_img_total;
                    n_pkt_left   = '0;
                    n_expect_hdr = 1'b1;
                end else if (pkt_after == '0) begin
                    n_expect_hdr = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_res.pixel_value  = pix_acc;
        o_res.repeat_count = rep;
        o_res.image_done   = done;
        o_res.clipped      = clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp4       <= 1'b0;
            r_img_total  <= PixelW'(1);
            r_expect_hdr <= 1'b1;
            r_run        <= 1'b0;
            r_pkt_left   <= '0;
            r_pos        <= '0;
            r_pix        <= '0;
            r_img_left   <= PixelW'(1);
        end else begin
            r_bpp4       <= n_bpp4;
            r_img_total  <= n_img_total;
            r_expect_hdr <= n_expect_hdr;
            r_run        <= n_run;
            r_pkt_left   <= n_pkt_left;
            r_pos        <= n_pos;
            r_pix        <= n_pix;
            r_img_left   <= n_img_left;
        end
    end

endmodule

FILE: rtl/core/tgarle_fifo.sv
// Result queue between the front end and the output port.
// Depends on tgarle_pkg for the result beat type.
module tgarle_fifo #(
    parameter int unsigned DEPTH = tgarle_pkg::QueueDepth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tgarle_pkg::t_result  i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output tgarle_pkg::t_result  o_data
);
    import tgarle_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    t_result          r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count, n_count;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        o_full   = (r_count == CntW'(DEPTH));
        o_empty  = (r_count == '0);
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CntW'(1);
        end
        o_data = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: rtl/core/tga_rle_pixel_decoder_core.sv
// Top level of the TGA RLE truecolor pixel decoder.
// Depends on tgarle_pkg, tgarle_front and tgarle_fifo.
//
//   channel   handshake                 payload
//   input     push / full               i_data_byte
//   result    empty / pop               o_pixel_value, o_repeat_count,
//                                       o_image_done, o_clipped
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte per clock; a pixel's result enters the queue the cycle its last
// byte is taken; from an empty queue it shows on the result ports next cycle.
// The front end's 32-bit pixel count compare and subtract sets the cycle.
// Input stalls only when the result queue (QUEUE_DEPTH beats) is full. Reset
// is sync active-low; config always ready, index 0/1 writes restart decoding.
module tga_rle_pixel_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = tgarle_pkg::QueueDepth
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [tgarle_pkg::ByteW-1:0]      i_data_byte,
    output logic                              empty,
    input  logic                              pop,
    output logic [tgarle_pkg::PixelW-1:0]     o_pixel_value,
    output logic [tgarle_pkg::RepeatW-1:0]    o_repeat_count,
    output logic                              o_image_done,
    output logic                              o_clipped,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tgarle_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [tgarle_pkg::CfgDataW-1:0]   i_cfg_data
);
    import tgarle_pkg::*;

    logic    q_full;
    logic    beat_in;
    logic    res_valid;
    t_result res;
    t_result q_head;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign beat_in     = push && !q_full;

    tgarle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_beat      (beat_in),
        .i_data_byte (i_data_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tgarle_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_head)
    );

    assign o_pixel_value  = q_head.pixel_value;
    assign o_repeat_count = q_head.repeat_count;
    assign o_image_done   = q_head.image_done;
    assign o_clipped      = q_head.clipped;

endmodule
